// ===== sv/insertion_sorter_u64_macros.svh =====
// Assertion macros for the insertion sorter checker.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef INSERTION_SORTER_U64_MACROS_SVH
`define INSERTION_SORTER_U64_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISORT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion sorter check failed");

// Next-cycle implication, disabled during reset.
`define ISORT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion sorter check failed");

`endif

// ===== sv/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
// Used by isort_cell, insertion_sorter_u64, isort_checker and the bench; depends on nothing.
package isort_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 64;

    typedef logic [KEY_W-1:0] key_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // place the broadcast key
        logic pop;     // shift the chain one place toward the head
    } cell_ctrl_t;

endpackage

// ===== sv/insertion_sorter_u64.sv =====
// Insertion sorter: one key accepted per cycle while filling; the batch_end word
// is inserted in its own cycle, and the first sorted word shows on the next cycle.
// Draining then gives one sorted word per cycle while out_stall is low, with
// input stalled throughout. The chain has CAPACITY cells. Reset empties every
// cell, clears the overflow flag and returns to filling; the key registers
// themselves keep no reset.
module insertion_sorter_u64 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  isort_pkg::key_t      key_value,
    input  logic                 batch_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output isort_pkg::key_t      sorted_value,
    output logic                 final_item,
    output logic                 overflow_flag
);
    import isort_pkg::*;

    localparam logic MODE_FILL  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    logic       mode_reg;
    logic       mode_next;
    logic       dropped_reg;
    logic       dropped_next;

    key_t       cell_val   [CAPACITY];
    logic       cell_valid [CAPACITY];
    logic       cell_le    [CAPACITY];

    cell_ctrl_t ctrl;
    logic       in_take;
    logic       full;
    logic       pop_last;

    // Input is held off for the whole drain; filling takes a word every cycle.
    assign in_stall = (mode_reg == MODE_DRAIN);
    assign in_take  = in_valid && !in_stall;

    // The chain fills from the head, so the top cell tells whether it is full.
    assign full = cell_valid[CAPACITY-1];

    // Drop a key that finds the chain full; it still closes the batch.
    assign ctrl.insert = in_take && !full;
    assign ctrl.pop    = (mode_reg == MODE_DRAIN) && !out_stall;

    // The head cell is the smallest key left; the word is final once the
    // cell above it is empty.
    assign out_valid     = (mode_reg == MODE_DRAIN) && cell_valid[0];
    assign sorted_value  = cell_val[0];
    assign final_item    = !cell_valid[1];
    assign overflow_flag = dropped_reg;

    assign pop_last = ctrl.pop && final_item;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            key_t prev_val;
            logic prev_valid;
            logic prev_le;
            key_t next_val;
            logic next_valid;

            if (i == 0)
            begin : g_head
                // Below the head sits an always-valid cell that holds.
                assign prev_val   = key_value;
                assign prev_valid = 1'b1;
                assign prev_le    = 1'b1;
            end
            else
            begin : g_body
                assign prev_val   = cell_val[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_le    = cell_le[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_tail
                assign next_val   = cell_val[i];
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_val   = cell_val[i+1];
                assign next_valid = cell_valid[i+1];
            end

            isort_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key_value),
                .prev_val   (prev_val),
                .prev_valid (prev_valid),
                .prev_le    (prev_le),
                .next_val   (next_val),
                .next_valid (next_valid),
                .val        (cell_val[i]),
                .valid      (cell_valid[i]),
                .le         (cell_le[i])
            );
        end
    endgenerate

    always_comb
    begin
        mode_next    = mode_reg;
        dropped_next = dropped_reg;
        case (mode_reg)
            MODE_FILL:
            begin
                // Record a drop, then switch to draining on the last word.
                if (in_take && full)
                begin
                    dropped_next = 1'b1;
                end
                if (in_take && batch_end)
                begin
                    mode_next = MODE_DRAIN;
                end
            end
            MODE_DRAIN:
            begin
                // Advance on each taken word; the final one reopens the batch.
                if (pop_last)
                begin
                    mode_next    = MODE_FILL;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                mode_next = MODE_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FILL;
            dropped_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

// ===== sv/isort_cell.sv =====
// One cell of the insertion chain: a key register and its valid bit.
// Depends on isort_pkg.
module isort_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::key_t        key,
    input  isort_pkg::key_t        prev_val,
    input  logic                   prev_valid,
    input  logic                   prev_le,
    input  isort_pkg::key_t        next_val,
    input  logic                   next_valid,
    output isort_pkg::key_t        val,
    output logic                   valid,
    output logic                   le
);
    import isort_pkg::*;

    key_t val_reg;
    key_t val_next;
    logic valid_reg;
    logic valid_next;

    // Stored key at or below the new key: hold, the new key lands above.
    assign le = valid_reg && (val_reg <= key);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.pop)
        begin
            val_next   = next_val;
            valid_next = next_valid;
        end
        else if (ctrl.insert && !le)
        begin
            // Take the new key if the cell below holds, else move its key up.
            val_next   = prev_le ? key : prev_val;
            valid_next = prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/isort_checker.sv =====
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on isort_pkg and insertion_sorter_u64_macros.svh.
`include "insertion_sorter_u64_macros.svh"

module isort_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 batch_end,
    input logic                 out_valid,
    input logic                 out_stall,
    input isort_pkg::key_t      sorted_value,
    input logic                 final_item
);
    import isort_pkg::*;

    // No new key is taken while sorted words are going out.
    `ISORT_ASSERT_NOW(a_no_take_in_drain, out_valid, in_stall)
    // Closing a batch always yields output on the next cycle.
    `ISORT_ASSERT_NEXT(a_batch_drains, in_valid && !in_stall && batch_end, out_valid)
    // The final word ends the run.
    `ISORT_ASSERT_NEXT(a_final_ends, out_valid && !out_stall && final_item, !out_valid)
    // A stalled word stays.
    `ISORT_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
    `ISORT_ASSERT_NEXT(a_hold_value, out_valid && out_stall, $stable(sorted_value))

endmodule

bind insertion_sorter_u64 isort_checker u_isort_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .batch_end    (batch_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_item   (final_item)
);

// ===== bench/tb.sv =====
// Self-checking bench for insertion_sorter_u64: stable batch sort of 64-bit keys.
// Needs isort_pkg and the sorter RTL; it predicts every sorted word on its own
// and checks each word the sorter hands out against that prediction.
`timescale 1ns / 100ps

module tb;

    import isort_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 285;
    localparam int MAX_GAP      = 12;
    localparam int SETTLE       = 2 * CAPACITY + 8;

    typedef struct {
        key_t value;
        logic last;
        logic ovf;
    } sorted_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    key_t key_value;
    logic batch_end;
    logic out_valid;
    logic out_stall;
    key_t sorted_value;
    logic final_item;
    logic overflow_flag;

    // Shadow copy of the sorter's state, advanced on every accepted key.
    key_t batch_store [CAPACITY];
    int   fill_level;
    logic dropped_flag;

    sorted_word_t sorted_expect [$];
    int           errors;
    int           cycles;
    int           words_sent;
    bit           send_quiet;
    bit           recv_quiet;

    insertion_sorter_u64 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_value     (key_value),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_value  (sorted_value),
        .final_item    (final_item),
        .overflow_flag (overflow_flag)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int idle_gap(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Insert one accepted key into the shadow store; on the batch end, queue
    // the whole sorted batch and empty the store. Greater keys move up, equal
    // keys stay below the newcomer, which keeps the sort stable.
    task automatic predict_sorted(input key_t k, input logic last);
        int pos;
        sorted_word_t w;
        if (fill_level < CAPACITY)
        begin
            pos = fill_level;
            while (pos > 0 && batch_store[pos-1] > k)
            begin
                batch_store[pos] = batch_store[pos-1];
                pos--;
            end
            batch_store[pos] = k;
            fill_level++;
        end
        else
        begin
            // Store full: drop the key and flag the batch.
            dropped_flag = 1'b1;
        end
        if (last)
        begin
            for (int i = 0; i < fill_level; i++)
            begin
                w.value = batch_store[i];
                w.last  = (i == fill_level - 1);
                w.ovf   = dropped_flag;
                sorted_expect.push_back(w);
            end
            fill_level   = 0;
            dropped_flag = 1'b0;
        end
    endtask

    // Send one word. Inputs change only at the rising edge; the stall is read
    // at the falling edge, where it is settled for the edge that follows.
    task automatic send_word(input key_t k, input logic last);
        int gap;
        bit taken;
        gap = idle_gap(send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_value <= k;
        batch_end <= last;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        predict_sorted(k, last);
        words_sent++;
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sorted_expect.size() != 0);
    endtask

    // Result side: draw a stall per word, then take the word and check it
    // against the oldest prediction.
    initial
    begin
        int gap;
        int taken_count;
        sorted_word_t w;
        key_t got_value;
        logic got_last;
        logic got_ovf;
        out_stall   = 1'b0;
        recv_quiet  = 1'b0;
        taken_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = idle_gap(recv_quiet);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got_value = sorted_value;
                got_last  = final_item;
                got_ovf   = overflow_flag;
                if (!out_valid)
                    @(posedge clk);
            end
            while (!out_valid);
            if (sorted_expect.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got value %h last %b ovf %b",
                         $realtime, got_value, got_last, got_ovf);
                errors++;
            end
            else
            begin
                w = sorted_expect.pop_front();
                if (got_value !== w.value)
                begin
                    $display("%0t: sorted_value expected %h got %h",
                             $realtime, w.value, got_value);
                    errors++;
                end
                if (got_last !== w.last)
                begin
                    $display("%0t: final_item expected %b got %b",
                             $realtime, w.last, got_last);
                    errors++;
                end
                if (got_ovf !== w.ovf)
                begin
                    $display("%0t: overflow_flag expected %b got %b",
                             $realtime, w.ovf, got_ovf);
                    errors++;
                end
            end
            // Alternate stretches of back-to-back draining with stalled ones.
            taken_count++;
            if (taken_count % 24 == 0)
                recv_quiet = ($urandom_range(0, 2) == 0);
            @(posedge clk);
        end
    end

    // A batch of one key comes straight back, with the last mark.
    task automatic test_single_key();
        send_word({$urandom, $urandom}, 1'b1);
    endtask

    // Field extremes; the first three arrive in descending order, so each shifts the keys already stored.
    task automatic test_extremes();
        send_word('1, 1'b0);
        send_word(key_t'(1), 1'b0);
        send_word('0, 1'b0);
        send_word({1'b1, {(KEY_W-1){1'b0}}}, 1'b1);
    endtask

    // Equal keys must both come out, one after the other.
    task automatic test_duplicates();
        send_word(key_t'(9), 1'b0);
        send_word(key_t'(2), 1'b0);
        send_word(key_t'(9), 1'b1);
    endtask

    // Fill the store in descending order, then end the batch on a key that is
    // dropped: the batch still comes out, flagged as overflowed.
    task automatic test_overflow();
        for (int i = 0; i < CAPACITY; i++)
            send_word(key_t'(64'hFFFF_0000_0000_0000 - 64'(i) * 64'h1111), 1'b0);
        send_word(key_t'(5), 1'b1);
    endtask

    // Random batches: mostly modest sizes, some at or past capacity, with key sets
    // drawn full width, from a narrow range (many ties) or from the extremes.
    task automatic test_random();
        int target;
        int size;
        int flavor;
        key_t k;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            size       = ($urandom_range(0, 5) == 0) ? $urandom_range(CAPACITY, CAPACITY + 6)
                                                     : $urandom_range(1, 12);
            flavor     = $urandom_range(0, 2);
            send_quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < size; i++)
            begin
                case (flavor)
                    0: k = {$urandom, $urandom};
                    1: k = key_t'($urandom_range(0, 7));
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: k = '0;
                            1: k = '1;
                            2: k = key_t'(1) << $urandom_range(0, KEY_W - 1);
                            default: k = ~(key_t'(1) << $urandom_range(0, KEY_W - 1));
                        endcase
                    end
                endcase
                send_word(k, i == size - 1);
                // Now and then pause in mid-batch until the sorter has drained.
                if ($urandom_range(0, 40) == 0)
                    wait_drained();
            end
        end
        send_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        key_value    = '0;
        batch_end    = 1'b0;
        fill_level   = 0;
        dropped_flag = 1'b0;
        errors       = 0;
        cycles       = 0;
        words_sent   = 0;
        send_quiet   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_key();
        test_extremes();
        wait_drained();
        test_duplicates();
        test_overflow();
        wait_drained();
        test_random();

        // Drain, then give the sorter time to show any stray word.
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
